// File: hdl/sws_pkg.sv
package sws_pkg;

  // Window and word geometry
  localparam int unsigned WINDOW_BYTES = 32;
  localparam int unsigned BYTE_W       = 8;
  localparam int unsigned SIG_W        = 16;

  // Fold constants: top bit test and the feedback pattern
  localparam int unsigned      SIG_TOP_BIT  = SIG_W - 1;
  localparam logic [SIG_W-1:0] SIG_FOLD_XOR = 16'h0003;

  // Configuration map
  localparam int unsigned PADDR_W    = 3;
  localparam int unsigned PDATA_W    = 32;
  localparam logic [0:0]  REG_TARGET = 1'b0;

  // Control word shared by the window chain and the signature unit
  typedef struct packed {
    logic advance;   // a word is taken this cycle
    logic restart;   // start of file: clear history first
  } sws_ctl_t;

  // One fold step without the incoming byte
  function automatic logic [SIG_W-1:0] sig_step(input logic [SIG_W-1:0] acc);
    logic [SIG_W-1:0] t;
    t = acc[SIG_TOP_BIT] ? (acc ^ SIG_FOLD_XOR) : acc;
    return {t[SIG_W-3:0], 2'b00};
  endfunction

  // Image of one byte bit after it has been folded through a whole window
  function automatic logic [SIG_W-1:0] evict_col(input int unsigned b);
    logic [SIG_W-1:0] a;
    a = SIG_W'(1) << b;
    for (int unsigned k = 0; k < WINDOW_BYTES; k++) begin
      a = sig_step(a);
    end
    return a;
  endfunction

  localparam logic [SIG_W-1:0] EVICT_COL [BYTE_W] = '{
    evict_col(0), evict_col(1), evict_col(2), evict_col(3),
    evict_col(4), evict_col(5), evict_col(6), evict_col(7)
  };

  // Contribution of the byte that leaves the window
  function automatic logic [SIG_W-1:0] evict_term(input logic [BYTE_W-1:0] b);
    logic [SIG_W-1:0] acc;
    acc = '0;
    for (int unsigned i = 0; i < BYTE_W; i++) begin
      if (b[i]) begin
        acc = acc ^ EVICT_COL[i];
      end
    end
    return acc;
  endfunction

endpackage

// File: hdl/sws_in_if.sv
interface sws_in_if;
  import sws_pkg::*;

  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] data_byte;
  logic              start_of_file;

  modport source (output valid, output data_byte, output start_of_file, input ready);
  modport sink   (input valid, input data_byte, input start_of_file, output ready);
endinterface

// File: hdl/sws_out_if.sv
interface sws_out_if;
  import sws_pkg::*;

  logic             valid;
  logic             ready;
  logic [SIG_W-1:0] signature;
  logic             match;

  modport source (output valid, output signature, output match, input ready);
  modport sink   (input valid, input signature, input match, output ready);
endinterface

// File: hdl/sws_cell.sv
module sws_cell (
  input  logic                 clk,
  input  logic                 rst,
  input  sws_pkg::sws_ctl_t    ctl,
  input  logic                 clear_en,
  input  logic [sws_pkg::BYTE_W-1:0] din,
  output logic [sws_pkg::BYTE_W-1:0] dout
);
  import sws_pkg::*;

  logic [BYTE_W-1:0] held;

  // Take the neighbor's byte on each word, or zero when history is dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      held <= '0;
    end else if (ctl.advance) begin
      held <= (ctl.restart && clear_en) ? '0 : din;
    end
  end

  assign dout = held;
endmodule

// File: hdl/sws_window.sv
module sws_window (
  input  logic                       clk,
  input  logic                       rst,
  input  sws_pkg::sws_ctl_t          ctl,
  input  logic [sws_pkg::BYTE_W-1:0] newest,
  output logic [sws_pkg::BYTE_W-1:0] oldest
);
  import sws_pkg::*;

  // tap[k] is the byte in cell k; cell 0 holds the oldest byte
  logic [BYTE_W-1:0] tap [WINDOW_BYTES+1];

  assign tap[WINDOW_BYTES] = newest;

  // Chain of byte cells, each shifting toward the old end
  for (genvar k = 0; k < WINDOW_BYTES; k++) begin : g_cell
    sws_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .ctl      (ctl),
      .clear_en (k != WINDOW_BYTES - 1),
      .din      (tap[k+1]),
      .dout     (tap[k])
    );
  end

  assign oldest = tap[0];
endmodule

// File: hdl/sws_fold.sv
module sws_fold (
  input  logic                       clk,
  input  logic                       rst,
  input  sws_pkg::sws_ctl_t          ctl,
  input  logic [sws_pkg::BYTE_W-1:0] newest,
  input  logic [sws_pkg::BYTE_W-1:0] oldest,
  output logic [sws_pkg::SIG_W-1:0]  sig_next
);
  import sws_pkg::*;

  logic [SIG_W-1:0] sig;

  // Roll the fold: age it one step, cancel the leaving byte, add the new one; on restart, new byte only
  always_comb begin
    if (ctl.restart) begin
      sig_next = {{(SIG_W-BYTE_W){1'b0}}, newest};
    end else begin
      sig_next = sig_step(sig) ^ evict_term(oldest)
               ^ {{(SIG_W-BYTE_W){1'b0}}, newest};
    end
  end

  // Hold the running signature of the window
  always_ff @(posedge clk) begin
    if (rst) begin
      sig <= '0;
    end else if (ctl.advance) begin
      sig <= sig_next;
    end
  end
endmodule

// File: hdl/sliding_window_signature_scanner.sv
// Sliding-window signature scanner.
// scan_in carries one byte per word with a start_of_file flag; scan_out returns
// one word per input word: the 16-bit signature of the last 32 bytes (oldest
// first) and match, set when it equals the target_signature register.
// Both channels use valid/ready; a word moves when both are high.
// The APB port holds target_signature at addresses 0-3; writes elsewhere are
// dropped and reads there return zero. Write it only while the block is idle.
// The result word is registered, valid the cycle after its input is accepted.
// Throughput: one word per cycle while scan_out.ready stays high. The window
// is a chain of 32 byte cells shifting once per word; the signature is updated
// incrementally by one fold step, the leaving byte's image and the new byte.
// start_of_file clears the whole window to zeros before the byte is stored.
// Reset (rst, synchronous) clears the window, the signature, the target and
// the output valid flag, not the held result word. When the receiver stalls,
// the result word holds and scan_in.ready drops until it is taken; a word is
// accepted in the same cycle that the waiting result leaves.
module sliding_window_signature_scanner (
  input  logic                        clk,
  input  logic                        rst,
  sws_in_if.sink                      scan_in,
  sws_out_if.source                   scan_out,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [sws_pkg::PADDR_W-1:0] paddr,
  input  logic [sws_pkg::PDATA_W-1:0] pwdata,
  output logic [sws_pkg::PDATA_W-1:0] prdata,
  output logic                        pready
);
  import sws_pkg::*;

  logic [SIG_W-1:0]  target;
  logic [SIG_W-1:0]  sig_next;
  logic [BYTE_W-1:0] oldest;
  logic              out_valid;
  logic [SIG_W-1:0]  out_sig;
  logic              out_match;
  logic              take;
  sws_ctl_t          ctl;

  // Configuration register
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      target <= '0;
    end else if (psel && penable && pwrite && (paddr[PADDR_W-1] == REG_TARGET)) begin
      target <= pwdata[SIG_W-1:0];
    end
  end

  always_comb begin
    unique case (paddr[PADDR_W-1])
      REG_TARGET: prdata = {{(PDATA_W-SIG_W){1'b0}}, target};
      default:    prdata = '0;
    endcase
  end

  // Accept when the output slot is free or draining this cycle
  assign scan_in.ready = !out_valid || scan_out.ready;
  assign take          = scan_in.valid && scan_in.ready;
  assign ctl.advance   = take;
  assign ctl.restart   = scan_in.start_of_file;

  sws_window u_window (
    .clk    (clk),
    .rst    (rst),
    .ctl    (ctl),
    .newest (scan_in.data_byte),
    .oldest (oldest)
  );

  sws_fold u_fold (
    .clk      (clk),
    .rst      (rst),
    .ctl      (ctl),
    .newest   (scan_in.data_byte),
    .oldest   (oldest),
    .sig_next (sig_next)
  );

  // Output register: load on accept, drop when taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (take) begin
      out_valid <= 1'b1;
    end else if (scan_out.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_sig   <= sig_next;
      out_match <= (sig_next == target);
    end
  end

  assign scan_out.valid     = out_valid;
  assign scan_out.signature = out_sig;
  assign scan_out.match     = out_match;
endmodule

// File: hdl/sws_checker.sv
module sws_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       in_valid,
  input logic                       in_ready,
  input logic [sws_pkg::BYTE_W-1:0] in_byte,
  input logic                       in_sof,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic [sws_pkg::SIG_W-1:0]  out_sig
);
  import sws_pkg::*;

  // Reset leaves no result pending
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result word pending after reset");

  // Every accepted word yields a result on the next cycle
  a_one_result: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> out_valid)
    else $error("accepted word produced no result");

  // A start of file leaves only the new byte in the signature
  a_sof_sig: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && in_sof) |=>
      (out_sig == {{(SIG_W-BYTE_W){1'b0}}, $past(in_byte)}))
    else $error("signature after start of file is not the lone byte");

  // A stalled result stays put
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_sig)))
    else $error("stalled result word changed");
endmodule

bind sliding_window_signature_scanner sws_checker u_sws_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (scan_in.valid),
  .in_ready  (scan_in.ready),
  .in_byte   (scan_in.data_byte),
  .in_sof    (scan_in.start_of_file),
  .out_valid (scan_out.valid),
  .out_ready (scan_out.ready),
  .out_sig   (scan_out.signature)
);

// File: tb/sliding_window_signature_scanner_tb.sv
module sliding_window_signature_scanner_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import sws_pkg::*;

  localparam int unsigned NUM_PHASES      = 8;
  localparam int unsigned WORDS_PER_PHASE = 200;
  localparam int unsigned DRAIN_LIMIT     = 2000;
  localparam int unsigned TAIL_CYCLES     = 4;
  localparam int unsigned HOLD_CYCLES     = 250;

  localparam logic [PADDR_W-1:0] ADDR_TARGET = PADDR_W'(4 * int'(REG_TARGET));
  localparam logic [PADDR_W-1:0] ADDR_SPARE  = PADDR_W'(4 * (int'(REG_TARGET) + 1));

  typedef struct packed {
    logic [SIG_W-1:0] signature;
    logic             match;
  } sig_word_t;

  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic              sof;
    logic              fixed;   // want is typed in, not predicted
    sig_word_t         want;
  } scan_row_t;

  typedef enum int unsigned {
    RX_FREE, RX_RANDOM, RX_PERIODIC, RX_SPARSE
  } rx_mode_e;

  typedef enum int unsigned {
    BYTES_UNIFORM, BYTES_ZERO_HEAVY, BYTES_ONES_HEAVY, BYTES_CORNER
  } byte_style_e;

  localparam int unsigned NUM_ROWS = 24;
  localparam scan_row_t SCAN_ROWS [NUM_ROWS] = '{
    '{8'h00, 1'b0, 1'b1, '{16'h0000, 1'b1}},
    '{8'h00, 1'b0, 1'b1, '{16'h0000, 1'b1}},
    '{8'hFF, 1'b1, 1'b1, '{16'h00FF, 1'b0}},
    '{8'h80, 1'b0, 1'b0, '{16'h0000, 1'b0}},
    '{8'h01, 1'b0, 1'b0, '{16'h0000, 1'b0}},
    '{8'h7F, 1'b0, 1'b0, '{16'h0000, 1'b0}},
    '{8'h80, 1'b1, 1'b1, '{16'h0080, 1'b0}},
    '{8'h00, 1'b1, 1'b1, '{16'h0000, 1'b1}},
    '{8'hFF, 1'b0, 1'b0, '{16'h0000, 1'b0}},
    '{8'hFF, 1'b0, 1'b0, '{16'h0000, 1'b0}},
    '{8'hFF, 1'b0, 1'b0, '{16'h0000, 1'b0}},
    '{8'hFF, 1'b0, 1'b0, '{16'h0000, 1'b0}},
    '{8'hFF, 1'b0, 1'b0, '{16'h0000, 1'b0}},
    '{8'hFF, 1'b0, 1'b0, '{16'h0000, 1'b0}},
    '{8'hFF, 1'b0, 1'b0, '{16'h0000, 1'b0}},
    '{8'hFF, 1'b0, 1'b0, '{16'h0000, 1'b0}},
    '{8'hFF, 1'b0, 1'b0, '{16'h0000, 1'b0}},
    '{8'hFF, 1'b0, 1'b0, '{16'h0000, 1'b0}},
    '{8'hFF, 1'b0, 1'b0, '{16'h0000, 1'b0}},
    '{8'hFF, 1'b0, 1'b0, '{16'h0000, 1'b0}},
    '{8'h55, 1'b1, 1'b1, '{16'h0055, 1'b0}},
    '{8'hAA, 1'b0, 1'b0, '{16'h0000, 1'b0}},
    '{8'hFE, 1'b1, 1'b1, '{16'h00FE, 1'b0}},
    '{8'h01, 1'b0, 1'b0, '{16'h0000, 1'b0}}
  };

  localparam logic [BYTE_W-1:0] CORNER_BYTES [6] = '{
    8'h00, 8'h01, 8'h7F, 8'h80, 8'hFE, 8'hFF
  };

  logic clk = 1'b0;
  logic rst;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [PADDR_W-1:0]  paddr;
  logic [PDATA_W-1:0]  pwdata;
  logic [PDATA_W-1:0]  prdata;
  logic                pready;

  sws_in_if  scan_in();
  sws_out_if scan_out();

  sliding_window_signature_scanner dut (
    .clk      (clk),
    .rst      (rst),
    .scan_in  (scan_in),
    .scan_out (scan_out),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  // Window model and expected signature words
  logic [BYTE_W-1:0] window_model [WINDOW_BYTES];
  int unsigned       oldest_model;
  logic [SIG_W-1:0]  target_model;
  sig_word_t         sig_expected [$];

  int unsigned mismatches;
  int unsigned burst_left;
  int unsigned hold_req_cycles;
  int unsigned hold_left;
  int unsigned rx_left;
  int unsigned rx_count;
  rx_mode_e    rx_mode;
  sig_word_t   sig_head;

  always #6 clk = ~clk;

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("%0t: mismatch on %s: got %h, expected %h", $realtime, what, got, want);
    mismatches++;
  endtask

  // Store a byte in the window copy, fold oldest to newest, and optionally keep it
  function automatic sig_word_t fold_after_byte(input logic [BYTE_W-1:0] b,
                                                input logic sof, input bit commit);
    logic [BYTE_W-1:0] win [WINDOW_BYTES];
    int unsigned       oldest;
    logic [SIG_W-1:0]  acc;
    sig_word_t         res;
    win    = window_model;
    oldest = oldest_model;
    if (sof) begin
      foreach (win[i]) win[i] = '0;
      oldest = 0;
    end
    win[oldest] = b;
    oldest = (oldest + 1) % WINDOW_BYTES;
    acc = '0;
    for (int unsigned k = 0; k < WINDOW_BYTES; k++) begin
      if (acc[SIG_W-1]) begin
        acc = acc ^ SIG_FOLD_XOR;
      end
      acc = acc << 2;
      acc = acc ^ SIG_W'(win[(oldest + k) % WINDOW_BYTES]);
    end
    res.signature = acc;
    res.match     = (acc == target_model);
    if (commit) begin
      window_model = win;
      oldest_model = oldest;
    end
    return res;
  endfunction

  function automatic logic [BYTE_W-1:0] pick_byte(input byte_style_e style);
    logic [BYTE_W-1:0] b;
    case (style)
      BYTES_ZERO_HEAVY: b = ($urandom_range(0, 3) == 0) ? BYTE_W'($urandom) : '0;
      BYTES_ONES_HEAVY: b = ($urandom_range(0, 3) == 0) ? BYTE_W'($urandom) : '1;
      BYTES_CORNER:     b = CORNER_BYTES[$urandom_range(0, 5)];
      default:          b = BYTE_W'($urandom_range(0, 255));
    endcase
    return b;
  endfunction

  // Offer one word in bursts with random gaps; predict on acceptance
  task automatic send_word(input logic [BYTE_W-1:0] b, input logic sof,
                           input logic fixed, input sig_word_t want);
    int unsigned gap;
    sig_word_t   pred;
    if (burst_left == 0) begin
      case ($urandom_range(0, 19))
        0, 1:             gap = $urandom_range(10, 30);
        2, 3, 4, 5, 6, 7: gap = 0;
        default:          gap = $urandom_range(1, 4);
      endcase
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(100, 300)
                                               : $urandom_range(1, 24);
      if (gap > 0) begin
        @(negedge clk);
        scan_in.valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    burst_left--;
    @(negedge clk);
    scan_in.valid         <= 1'b1;
    scan_in.data_byte     <= b;
    scan_in.start_of_file <= sof;
    do @(posedge clk); while (!scan_in.ready);
    pred = fold_after_byte(b, sof, 1'b1);
    sig_expected.push_back(fixed ? want : pred);
  endtask

  // Drop valid and wait until every expected word has come back
  task automatic drain_outputs();
    @(negedge clk);
    scan_in.valid <= 1'b0;
    burst_left = 0;
    while (sig_expected.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [PADDR_W-1:0] addr, input logic [PDATA_W-1:0] data);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (addr == ADDR_TARGET) begin
      target_model = data[SIG_W-1:0];
    end
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic cfg_check_target();
    logic [PDATA_W-1:0] got;
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= ADDR_TARGET;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    got = prdata;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    if (got !== PDATA_W'(target_model)) begin
      report_mismatch("target_signature readback", got, PDATA_W'(target_model));
    end
  endtask

  // Receiver: long hold-off on request, else a pattern that changes over time
  always @(negedge clk) begin
    if (hold_req_cycles > 0) begin
      hold_left       = hold_req_cycles;
      hold_req_cycles = 0;
    end
    rx_count++;
    if (hold_left > 0) begin
      hold_left--;
      scan_out.ready <= 1'b0;
    end else begin
      if (rx_left == 0) begin
        rx_mode = rx_mode_e'($urandom_range(0, 3));
        rx_left = $urandom_range(20, 300);
      end
      rx_left--;
      case (rx_mode)
        RX_FREE:     scan_out.ready <= 1'b1;
        RX_RANDOM:   scan_out.ready <= ($urandom_range(0, 3) != 0);
        RX_PERIODIC: scan_out.ready <= ((rx_count % 5) != 0);
        default:     scan_out.ready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  // Compare each accepted word with the oldest expectation
  always @(posedge clk) begin
    if (!rst && scan_out.valid && scan_out.ready) begin
      if (sig_expected.size() == 0) begin
        report_mismatch("unexpected word", {15'b0, scan_out.match, scan_out.signature}, '0);
      end else begin
        sig_head = sig_expected.pop_front();
        if (scan_out.signature !== sig_head.signature) begin
          report_mismatch("signature", 32'(scan_out.signature), 32'(sig_head.signature));
        end
        if (scan_out.match !== sig_head.match) begin
          report_mismatch("match", 32'(scan_out.match), 32'(sig_head.match));
        end
      end
    end
  end

  initial begin
    #3ms;
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    int unsigned       sent;
    int unsigned       file_len;
    int unsigned       waited;
    logic [SIG_W-1:0]  tgt;
    logic [BYTE_W-1:0] first_byte;
    logic              first_sof;
    logic              lookahead;
    logic              sof;
    byte_style_e       style;

    rst                   = 1'b1;
    scan_in.valid         = 1'b0;
    scan_in.data_byte     = '0;
    scan_in.start_of_file = 1'b0;
    scan_out.ready        = 1'b0;
    psel                  = 1'b0;
    penable               = 1'b0;
    pwrite                = 1'b0;
    paddr                 = '0;
    pwdata                = '0;
    foreach (window_model[i]) window_model[i] = '0;
    oldest_model    = 0;
    target_model    = '0;
    mismatches      = 0;
    burst_left      = 0;
    hold_req_cycles = 0;
    hold_left       = 0;
    rx_left         = 0;
    rx_count        = 0;
    rx_mode         = RX_FREE;

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Reset value of the target, then the directed rows
    cfg_check_target();
    foreach (SCAN_ROWS[i]) begin
      send_word(SCAN_ROWS[i].data, SCAN_ROWS[i].sof, SCAN_ROWS[i].fixed, SCAN_ROWS[i].want);
    end

    for (int unsigned phase = 0; phase < NUM_PHASES; phase++) begin
      drain_outputs();
      lookahead  = 1'b0;
      first_byte = BYTE_W'($urandom_range(0, 255));
      first_sof  = 1'($urandom_range(0, 1));
      case (phase % 4)
        0:       tgt = (phase == 0) ? 16'hFFFF : 16'h0000;
        1: begin
          // aim the target at the next word so it hits
          tgt       = fold_after_byte(first_byte, first_sof, 1'b0).signature;
          lookahead = 1'b1;
        end
        2:       tgt = SIG_W'($urandom_range(0, 65535));
        default: tgt = {8'h00, BYTE_W'($urandom_range(0, 255))};
      endcase
      cfg_write(ADDR_SPARE, $urandom);
      cfg_write(ADDR_TARGET, {16'($urandom_range(0, 65535)), tgt});
      cfg_check_target();

      sent = 0;
      if (lookahead) begin
        send_word(first_byte, first_sof, 1'b0, '0);
        sent++;
      end
      while (sent < WORDS_PER_PHASE) begin
        case ($urandom_range(0, 9))
          0, 1:    file_len = $urandom_range(1, 8);
          8:       file_len = $urandom_range(81, 140);
          default: file_len = $urandom_range(20, 80);
        endcase
        style = byte_style_e'($urandom_range(0, 3));
        for (int unsigned j = 0; j < file_len && sent < WORDS_PER_PHASE; j++) begin
          if (sent == 40 && (phase == 1 || phase == 5)) begin
            hold_req_cycles = HOLD_CYCLES;
          end
          if (sent == 100 && (phase == 3 || phase == 6)) begin
            drain_outputs();
          end
          // mostly well-formed files; a stray mid-file restart now and then
          sof = (j == 0) ? ($urandom_range(0, 9) != 0) : ($urandom_range(0, 39) == 0);
          if (j == 0 && sof && phase % 4 == 3 && $urandom_range(0, 2) == 0) begin
            send_word(tgt[BYTE_W-1:0], 1'b1, 1'b0, '0);
          end else begin
            send_word(pick_byte(style), sof, 1'b0, '0);
          end
          sent++;
        end
      end
    end

    // Wait out the last words, bounded
    @(negedge clk);
    scan_in.valid <= 1'b0;
    waited = 0;
    while (sig_expected.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    if (sig_expected.size() != 0) begin
      report_mismatch("words never returned", sig_expected.size(), 0);
    end
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// File: sim.f
hdl/sws_pkg.sv
hdl/sws_in_if.sv
hdl/sws_out_if.sv
hdl/sws_cell.sv
hdl/sws_window.sv
hdl/sws_fold.sv
hdl/sliding_window_signature_scanner.sv
hdl/sws_checker.sv
tb/sliding_window_signature_scanner_tb.sv
